// File: rtl/core/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

    // field widths
    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int DATA_W    = 32;
    localparam int ROWS_W    = 13;
    localparam int CFG_IDX_W = 2;

    // arithmetic widths
    localparam int K_W    = 44;               // |k| = index * step
    localparam int K_LO_W = 22;               // low split of |k|
    localparam int K_HI_W = K_W - K_LO_W;
    localparam int MAG_W  = 64;               // |rho| * norm
    localparam int MAG_LO_W = 32;
    localparam int MAG_HI_W = MAG_W - MAG_LO_W;
    localparam int K2_W   = 2 * K_W + 1;      // kx^2 + ky^2
    localparam int SQ_W   = 2 * K_W;
    localparam int FRAC_W = 16;
    localparam int EN_W   = K_W + MAG_W;      // field numerator
    localparam int K2E_W  = K2_W + FRAC_W;    // field denominator
    localparam int PP_W   = K_HI_W + MAG_HI_W;

    // quotient bits below the saturation limit
    localparam int QUO_W   = DATA_W - 1;
    localparam int DIV_LAT = QUO_W + 1;

    localparam int Y_POINTS_MAX = 4096;

    // stage counts: front end, divider, output register
    localparam int PRE_LAT  = 5;
    localparam int PIPE_LAT = PRE_LAT + DIV_LAT + 1;

    // result lanes
    localparam int LANES   = 6;
    localparam int E_LANES = 4;

    // register reset values
    localparam logic [DATA_W-1:0] KX_STEP_RST = 32'd411775;
    localparam logic [DATA_W-1:0] KY_STEP_RST = 32'd411775;
    localparam logic [DATA_W-1:0] NORM_RST    = 32'd1048576;
    localparam logic [ROWS_W-1:0] ROWS_RST    = 13'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KX_STEP = 2'd0,
        CFG_KY_STEP = 2'd1,
        CFG_NORM    = 2'd2,
        CFG_ROWS    = 2'd3
    } t_cfg_idx;

    // per-lane sign of the result and origin flag
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } t_side;

endpackage

// File: rtl/core/spc_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. The first stage only
// checks whether the quotient reaches the saturation limit.
module spc_divider #(
    parameter int NW = spc_pkg::MAG_W,
    parameter int DW = spc_pkg::K2_W
) (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [NW-1:0]              i_num,
    input  logic [DW-1:0]              i_den,
    output logic [spc_pkg::QUO_W-1:0]  o_quo,
    output logic                       o_ovf
);
    import spc_pkg::*;

    localparam int STEPS = QUO_W + 1;
    localparam int CW    = DW + STEPS;

    logic [NW-1:0]    r_rem [STEPS];
    logic [DW-1:0]    r_den [STEPS];
    logic [QUO_W-1:0] r_quo [STEPS];
    logic             r_ovf [STEPS];

    logic [NW-1:0]    n_rem [STEPS];
    logic [QUO_W-1:0] n_quo [STEPS];
    logic             n_ovf [STEPS];
    logic [NW-1:0]    p_rem [STEPS];
    logic [DW-1:0]    p_den [STEPS];
    logic [CW-1:0]    sh    [STEPS];
    logic             ge    [STEPS];

    // trial subtract of den << bit at every stage after the first
    always_comb begin
        p_rem[0] = i_num;
        p_den[0] = i_den;
        sh[0]    = CW'(i_den) << (STEPS - 1);
        ge[0]    = CW'(i_num) >= sh[0];
        n_rem[0] = i_num;
        n_quo[0] = '0;
        n_ovf[0] = ge[0];
        for (int s = 1; s < STEPS; s++) begin
            p_rem[s] = r_rem[s-1];
            p_den[s] = r_den[s-1];
            sh[s]    = CW'(p_den[s]) << (STEPS - 1 - s);
            ge[s]    = CW'(p_rem[s]) >= sh[s];
            n_rem[s] = ge[s] ? (p_rem[s] - sh[s][NW-1:0]) : p_rem[s];
            n_quo[s] = r_quo[s-1];
            n_quo[s][STEPS-1-s] = ge[s];
            n_ovf[s] = r_ovf[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int s = 0; s < STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= p_den[s];
                r_quo[s] <= n_quo[s];
                r_ovf[s] <= n_ovf[s];
            end
        end
    end

    assign o_quo = r_quo[STEPS-1];
    assign o_ovf = r_ovf[STEPS-1];

endmodule

// File: rtl/core/spectral_poisson_coefficient.sv
`timescale 1ns / 1ps

// Spectral Poisson solve for one Fourier coefficient per cycle. Each input
// transaction (column index, row index, complex density) yields one result
// transaction with potential and x/y field coefficients in saturated Q16.16;
// rows in the upper half use negative wavenumbers and the origin returns all
// zeros. The pipeline is fully streaming, one transaction per cycle unless
// stalled: 5 front-end stages (wavenumbers, products, k^2), 32 divider
// stages, one output register. An output stall with a result offered
// freezes the whole pipeline and is passed straight back to the input.
module spectral_poisson_coefficient (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [spc_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [spc_pkg::COL_W-1:0]         i_col_index,
    input  logic [spc_pkg::ROW_W-1:0]         i_row_index,
    input  logic signed [spc_pkg::DATA_W-1:0] i_rho_real,
    input  logic signed [spc_pkg::DATA_W-1:0] i_rho_imag,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [spc_pkg::DATA_W-1:0] o_phi_real,
    output logic signed [spc_pkg::DATA_W-1:0] o_phi_imag,
    output logic signed [spc_pkg::DATA_W-1:0] o_ex_real,
    output logic signed [spc_pkg::DATA_W-1:0] o_ex_imag,
    output logic signed [spc_pkg::DATA_W-1:0] o_ey_real,
    output logic signed [spc_pkg::DATA_W-1:0] o_ey_imag
);
    import spc_pkg::*;

    // configuration registers
    logic [DATA_W-1:0] r_kx_step, r_ky_step, r_norm;
    logic [ROWS_W-1:0] r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kx_step <= KX_STEP_RST;
            r_ky_step <= KY_STEP_RST;
            r_norm    <= NORM_RST;
            r_rows    <= ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KX_STEP: r_kx_step <= i_cfg_data;
                CFG_KY_STEP: r_ky_step <= i_cfg_data;
                CFG_NORM:    r_norm    <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data[ROWS_W-1:0];
                default:     r_rows    <= r_rows;
            endcase
        end
    end

    // global pipeline enable
    logic                ce;
    logic [PIPE_LAT-1:0] r_vld;

    assign ce      = !r_vld[PIPE_LAT-1] || !i_stall;
    assign o_stall = !ce;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // stage 1: signed row frequency and magnitudes
    logic [ROWS_W-1:0] ny, half, ix2;
    logic [ROW_W-1:0]  sm;
    logic              nky, nre, nim;
    logic [DATA_W-1:0] rre, rim;

    always_comb begin
        ny   = (r_rows > ROWS_W'(Y_POINTS_MAX)) ? ROWS_W'(Y_POINTS_MAX) : r_rows;
        half = ROWS_W'(((ROWS_W + 1)'(ny) + (ROWS_W + 1)'(1)) >> 1);
        ix2  = ROWS_W'(i_row_index);
        sm   = i_row_index;
        nky  = 1'b0;
        if (ix2 >= half) begin
            if (ix2 >= ny) begin
                sm = ROW_W'(ix2 - ny);
            end else begin
                sm  = ROW_W'(ny - ix2);
                nky = 1'b1;
            end
        end
        nre = i_rho_real[DATA_W-1];
        nim = i_rho_imag[DATA_W-1];
        rre = nre ? (~i_rho_real + 1'b1) : i_rho_real;
        rim = nim ? (~i_rho_imag + 1'b1) : i_rho_imag;
    end

    logic [COL_W-1:0]  r1_ix1;
    logic [ROW_W-1:0]  r1_sm;
    logic [DATA_W-1:0] r1_rre, r1_rim;
    logic [LANES-1:0]  r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_ix1 <= i_col_index;
            r1_sm  <= sm;
            r1_rre <= rre;
            r1_rim <= rim;
            r1_neg <= {!(nky ^ nre), nky ^ nim, !nre, nim, nim, nre};
        end
    end

    // stage 2: wavenumbers and scaled density
    logic [K_W-1:0]   r2_kxm, r2_kym;
    logic [MAG_W-1:0] r2_mre, r2_mim;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_kxm <= K_W'(r1_ix1) * K_W'(r_kx_step);
            r2_kym <= K_W'(r1_sm) * K_W'(r_ky_step);
            r2_mre <= MAG_W'(r1_rre) * MAG_W'(r_norm);
            r2_mim <= MAG_W'(r1_rim) * MAG_W'(r_norm);
            r2_neg <= r1_neg;
        end
    end

    // stage 3: partial products of the squares and field numerators
    logic [SQ_W-1:0]  r3_hh [2];
    logic [SQ_W-1:0]  r3_hl [2];
    logic [SQ_W-1:0]  r3_ll [2];
    logic [PP_W-1:0]  r3_pp [E_LANES][4];
    logic [MAG_W-1:0] r3_mre, r3_mim;
    logic [K_W-1:0]   kk [E_LANES];
    logic [MAG_W-1:0] mm [E_LANES];
    logic [K_W-1:0]   ks [2];

    always_comb begin
        ks[0] = r2_kxm;
        ks[1] = r2_kym;
        for (int e = 0; e < E_LANES; e++) begin
            kk[e] = (e < 2) ? r2_kxm : r2_kym;
            mm[e] = (e % 2 == 1) ? r2_mre : r2_mim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < 2; a++) begin
                r3_hh[a] <= SQ_W'(ks[a][K_W-1:K_LO_W]) * SQ_W'(ks[a][K_W-1:K_LO_W]);
                r3_hl[a] <= SQ_W'(ks[a][K_W-1:K_LO_W]) * SQ_W'(ks[a][K_LO_W-1:0]);
                r3_ll[a] <= SQ_W'(ks[a][K_LO_W-1:0]) * SQ_W'(ks[a][K_LO_W-1:0]);
            end
            for (int e = 0; e < E_LANES; e++) begin
                r3_pp[e][0] <= PP_W'(kk[e][K_W-1:K_LO_W]) * PP_W'(mm[e][MAG_W-1:MAG_LO_W]);
                r3_pp[e][1] <= PP_W'(kk[e][K_W-1:K_LO_W]) * PP_W'(mm[e][MAG_LO_W-1:0]);
                r3_pp[e][2] <= PP_W'(kk[e][K_LO_W-1:0]) * PP_W'(mm[e][MAG_W-1:MAG_LO_W]);
                r3_pp[e][3] <= PP_W'(kk[e][K_LO_W-1:0]) * PP_W'(mm[e][MAG_LO_W-1:0]);
            end
            r3_mre <= r2_mre;
            r3_mim <= r2_mim;
            r3_neg <= r2_neg;
        end
    end

    // stage 4: sum partial products
    logic [SQ_W-1:0]  r4_sq [2];
    logic [EN_W-1:0]  r4_en [E_LANES];
    logic [MAG_W-1:0] r4_mre, r4_mim;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < 2; a++) begin
                r4_sq[a] <= (r3_hh[a] << (2 * K_LO_W)) + (r3_hl[a] << (K_LO_W + 1))
                          + r3_ll[a];
            end
            for (int e = 0; e < E_LANES; e++) begin
                r4_en[e] <= (EN_W'(r3_pp[e][0]) << (K_LO_W + MAG_LO_W))
                          + (EN_W'(r3_pp[e][1]) << K_LO_W)
                          + (EN_W'(r3_pp[e][2]) << MAG_LO_W)
                          + EN_W'(r3_pp[e][3]);
            end
            r4_mre <= r3_mre;
            r4_mim <= r3_mim;
            r4_neg <= r3_neg;
        end
    end

    // stage 5: k^2 and origin check
    logic [K2_W-1:0]  r5_k2;
    logic             r5_zero;
    logic [EN_W-1:0]  r5_en [E_LANES];
    logic [MAG_W-1:0] r5_mre, r5_mim;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_k2   <= K2_W'(r4_sq[0]) + K2_W'(r4_sq[1]);
            r5_zero <= (r4_sq[0] == '0) && (r4_sq[1] == '0);
            r5_en   <= r4_en;
            r5_mre  <= r4_mre;
            r5_mim  <= r4_mim;
            r5_neg  <= r4_neg;
        end
    end

    // dividers: potential lanes over k^2, field lanes over k^2 << 16
    logic [QUO_W-1:0] quo [LANES];
    logic             ovf [LANES];
    logic [K2E_W-1:0] k2e;

    assign k2e = {r5_k2, {FRAC_W{1'b0}}};

    spc_divider #(.NW(MAG_W), .DW(K2_W)) u_div_phi_re (
        .i_clk (i_clk), .i_ce (ce), .i_num (r5_mre), .i_den (r5_k2),
        .o_quo (quo[0]), .o_ovf (ovf[0])
    );

    spc_divider #(.NW(MAG_W), .DW(K2_W)) u_div_phi_im (
        .i_clk (i_clk), .i_ce (ce), .i_num (r5_mim), .i_den (r5_k2),
        .o_quo (quo[1]), .o_ovf (ovf[1])
    );

    for (genvar g = 0; g < E_LANES; g++) begin : g_field
        spc_divider #(.NW(EN_W), .DW(K2E_W)) u_div_e (
            .i_clk (i_clk), .i_ce (ce), .i_num (r5_en[g]), .i_den (k2e),
            .o_quo (quo[g+2]), .o_ovf (ovf[g+2])
        );
    end

    // sideband delay matching the divider
    t_side r_side [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= '{neg: r5_neg, zero: r5_zero};
            for (int s = 1; s < DIV_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // output register: sign and saturation
    logic [DATA_W-1:0] n_out [LANES];
    logic [DATA_W-1:0] r_out [LANES];
    t_side             side;

    always_comb begin
        side = r_side[DIV_LAT-1];
        for (int l = 0; l < LANES; l++) begin
            if (side.zero) begin
                n_out[l] = '0;
            end else if (ovf[l]) begin
                n_out[l] = side.neg[l] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
            end else if (side.neg[l]) begin
                n_out[l] = ~{1'b0, quo[l]} + 1'b1;
            end else begin
                n_out[l] = {1'b0, quo[l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= n_out;
        end
    end

    assign o_phi_real = r_out[0];
    assign o_phi_imag = r_out[1];
    assign o_ex_real  = r_out[2];
    assign o_ex_imag  = r_out[3];
    assign o_ey_real  = r_out[4];
    assign o_ey_imag  = r_out[5];

endmodule

// File: rtl/core/spc_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the streaming handshake.
module spc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [spc_pkg::DATA_W-1:0] o_phi_real,
    input logic signed [spc_pkg::DATA_W-1:0] o_ey_imag
);

    // held result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // held result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_phi_real) && $stable(o_ey_imag))
        else $error("result changed while stalled");

    // input is held back exactly when a finished result is blocked
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output backpressure");

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind spectral_poisson_coefficient spc_checker u_spc_checker (.*);

// File: verif/tb_spectral_poisson_coefficient.sv
`timescale 1ns / 1ps

module tb_spectral_poisson_coefficient;
    import spc_pkg::*;

    typedef struct {
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_coef;

    typedef struct {
        logic signed [DATA_W-1:0] phi_re, phi_im, ex_re, ex_im, ey_re, ey_im;
    } t_field;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [DATA_W-1:0]         i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [COL_W-1:0]          i_col_index = '0;
    logic [ROW_W-1:0]          i_row_index = '0;
    logic signed [DATA_W-1:0]  i_rho_real = '0;
    logic signed [DATA_W-1:0]  i_rho_imag = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [DATA_W-1:0]  o_phi_real, o_phi_imag, o_ex_real, o_ex_imag;
    logic signed [DATA_W-1:0]  o_ey_real, o_ey_imag;

    // model copy of the registers
    logic [DATA_W-1:0] kx_step = KX_STEP_RST;
    logic [DATA_W-1:0] ky_step = KY_STEP_RST;
    logic [DATA_W-1:0] norm_scale = NORM_RST;
    logic [ROWS_W-1:0] rows_in_use = ROWS_RST;

    t_coef  coef_q[$];
    t_field field_q[$];
    int     fail_cnt = 0;
    bit     coef_taken = 0;
    bit     burst_mode = 0;
    int     send_gap = 0;
    int     stall_left = 0;

    spectral_poisson_coefficient DUT (.*);

    always #1 i_clk = ~i_clk;

    // magnitude and sign to saturated Q16.16
    function automatic logic [DATA_W-1:0] sat_q16(logic [127:0] mag, logic neg);
        if (neg)
            return (mag >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [127:0] abs_q16(logic [DATA_W-1:0] v);
        return v[31] ? (128'h1_0000_0000 - {96'd0, v}) : {96'd0, v};
    endfunction

    // potential and field for one density coefficient
    function automatic t_field solve_coef(t_coef c);
        t_field f;
        logic [127:0] kxm, kym, k2, k2e, mre, mim;
        logic nre, nim, nky;
        int unsigned ny, sm;
        nre = c.re[31];
        nim = c.im[31];
        nky = 1'b0;
        ny = (rows_in_use > Y_POINTS_MAX) ? Y_POINTS_MAX : rows_in_use;
        sm = c.row;
        // upper rows wrap to negative frequency
        if (c.row >= (ny + 1) / 2) begin
            if (c.row >= ny) begin
                sm = c.row - ny;
            end else begin
                sm = ny - c.row;
                nky = 1'b1;
            end
        end
        kxm = 128'(c.col) * 128'(kx_step);
        kym = 128'(sm) * 128'(ky_step);
        k2 = kxm * kxm + kym * kym;
        f = '{default: '0};
        if (k2 == 0) return f;
        k2e = k2 << FRAC_W;
        mre = abs_q16(c.re) * 128'(norm_scale);
        mim = abs_q16(c.im) * 128'(norm_scale);
        f.phi_re = sat_q16(mre / k2, nre);
        f.phi_im = sat_q16(mim / k2, nim);
        // E = -i*(k/k2)*rho
        f.ex_re = sat_q16((kxm * mim) / k2e, nim);
        f.ex_im = sat_q16((kxm * mre) / k2e, !nre);
        f.ey_re = sat_q16((kym * mim) / k2e, nky != nim);
        f.ey_im = sat_q16((kym * mre) / k2e, nky == nre);
        return f;
    endfunction

    function automatic logic [DATA_W-1:0] pick_rho();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h1_FFFF)) - 32'sh1_0000);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
            default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic add_coef(int col, int row, logic [DATA_W-1:0] re, logic [DATA_W-1:0] im);
        t_coef c;
        c.col = COL_W'(col);
        c.row = ROW_W'(row);
        c.re = re;
        c.im = im;
        coef_q.push_back(c);
    endtask

    task automatic add_random(int n);
        int ny;
        repeat (n) begin
            ny = (rows_in_use > Y_POINTS_MAX) ? Y_POINTS_MAX : rows_in_use;
            add_coef($urandom_range(0, 7) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 48),
                     ($urandom_range(0, 5) == 0 || ny < 1) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, ny - 1),
                     pick_rho(), pick_rho());
        end
    endtask

    // wait until every transaction has drained out of the pipeline
    task automatic drain();
        while (coef_q.size() != 0 || i_valid || field_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_KX_STEP: kx_step = data;
            CFG_KY_STEP: ky_step = data;
            CFG_NORM:    norm_scale = data;
            CFG_ROWS:    rows_in_use = data[ROWS_W-1:0];
        endcase
    endtask

    task automatic run_phase(logic [DATA_W-1:0] kx, logic [DATA_W-1:0] ky,
                             logic [DATA_W-1:0] nrm, logic [DATA_W-1:0] rows, int n);
        drain();
        write_reg(CFG_KX_STEP, kx);
        write_reg(CFG_KY_STEP, ky);
        write_reg(CFG_NORM, nrm);
        write_reg(CFG_ROWS, rows);
        burst_mode = $urandom_range(0, 1);
        add_random(n);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_coef c;
        logic  nxt_valid;
        nxt_valid = i_valid;
        if (i_rst_n && (!i_valid || coef_taken)) begin
            coef_taken = 0;
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (coef_q.size() != 0) begin
                c = coef_q.pop_front();
                i_col_index <= c.col;
                i_row_index <= c.row;
                i_rho_real <= c.re;
                i_rho_imag <= c.im;
                nxt_valid = 1'b1;
                send_gap = burst_mode ? 0 : $urandom_range(0, 17);
            end
        end
        i_valid <= nxt_valid;
    end

    // accepted inputs feed the predictor
    always @(posedge i_clk) begin
        t_coef c;
        if (i_rst_n && i_valid && !o_stall) begin
            c.col = i_col_index;
            c.row = i_row_index;
            c.re = i_rho_real;
            c.im = i_rho_imag;
            field_q.push_back(solve_coef(c));
            coef_taken = 1;
        end
    end

    // output stall pattern
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_field f;
        if (i_rst_n && o_valid && !i_stall) begin
            if (field_q.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_cnt++;
            end else begin
                f = field_q.pop_front();
                check_field("phi_real", f.phi_re, o_phi_real);
                check_field("phi_imag", f.phi_im, o_phi_imag);
                check_field("ex_real", f.ex_re, o_ex_real);
                check_field("ex_imag", f.ex_im, o_ex_imag);
                check_field("ey_real", f.ey_re, o_ey_real);
                check_field("ey_imag", f.ey_im, o_ey_imag);
            end
            stall_left = burst_mode ? 0 : $urandom_range(0, 17);
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: origin, row zero, Nyquist row, wrapped rows, field extremes
        add_coef(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_coef(0, 0, 32'h0001_0000, 32'hFFFF_0000);
        add_coef(1, 0, 32'h0001_0000, 32'hFFFF_0000);
        add_coef(4095, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        add_coef(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_coef(0, 32, 32'h0001_0000, 32'h0002_0000);
        add_coef(3, 32, 32'hFFFF_0000, 32'h0001_0000);
        add_coef(0, 31, 32'h0001_0000, 32'h0001_0000);
        add_coef(0, 63, 32'h8000_0000, 32'h8000_0000);
        add_coef(5, 64, 32'h0000_0000, 32'h0003_0000);
        add_coef(0, 4095, 32'h1234_5678, 32'hEDCB_A988);
        add_coef(4095, 4095, 32'h7FFF_FFFF, 32'h8000_0000);
        add_coef(2048, 17, 32'h0000_0001, 32'hFFFF_FFFF);
        add_coef(1, 1, 32'h8000_0000, 32'h0000_0000);
        add_random(90);

        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4096, 80);
        run_phase(32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 2, 70);
        run_phase(32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 63, 70);
        run_phase(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8191, 40);
        run_phase(32'h0000_1000, 32'h0003_0000, 32'h0100_0000, 0, 60);
        run_phase(32'h0006_487F, 32'h0000_8000, 32'h0010_0000, 1, 60);
        run_phase($urandom(), $urandom(), $urandom(), $urandom_range(2, 4096), 80);
        run_phase(32'h0000_0100, 32'h0000_0100, 32'h0000_0000, 4097, 40);
        run_phase($urandom_range(1, 32'h000F_FFFF), $urandom_range(1, 32'h000F_FFFF),
                  $urandom(), $urandom_range(2, 300), 110);

        drain();
        if (fail_cnt == 0) begin
            $display("tb_spectral_poisson_coefficient: PASS");
        end else begin
            $display("tb_spectral_poisson_coefficient: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_spectral_poisson_coefficient: FAIL");
        $finish;
    end

endmodule
